[rtl/hmac_sha1_fixed_key_mac_assert.svh]
// Assertion macros for the MAC block
`ifndef HMAC_SHA1_FIXED_KEY_MAC_ASSERT_SVH
`define HMAC_SHA1_FIXED_KEY_MAC_ASSERT_SVH

// check that a condition implies a consequence in the same cycle
`define ASSERT_IMPLY(label, clk, rst, cond, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
      else $error("assertion failed");

// check that a condition implies a consequence in the next cycle
`define ASSERT_NEXT(label, clk, rst, cond, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
      else $error("assertion failed");

`endif

[rtl/hsha_pkg.sv]
package hsha_pkg;
   localparam int KeyRegs = 8;
   localparam int CsrIdxWidth = 3;
   localparam logic [31:0] IpadWord = 32'h36363636;
   localparam logic [31:0] OpadWord = 32'h5c5c5c5c;
   localparam logic [31:0] InnerLen = 32'd576;
   localparam logic [31:0] OuterLen = 32'd672;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_ROUND,
      ST_FOLD,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic       load;
      logic       round;
      logic       fold;
      logic       init_iv;
      logic [6:0] rnd;
   } core_ctl_type;

   function automatic logic [31:0] sha_k(input logic [6:0] r);
      if (r < 7'd20) return 32'h5a827999;
      else if (r < 7'd40) return 32'h6ed9eba1;
      else if (r < 7'd60) return 32'h8f1bbcdc;
      else return 32'hca62c1d6;
   endfunction
endpackage

[rtl/hsha_round.sv]
module hsha_round
   import hsha_pkg::*;
(
   input  logic         clock,
   input  core_ctl_type ctl,
   input  logic [511:0] block,
   output logic [159:0] digest
);
   logic [31:0] w_ff [16];
   logic [31:0] w_in [16];
   logic [31:0] h_ff [5];
   logic [31:0] h_in [5];
   logic [31:0] v_ff [5];
   logic [31:0] v_in [5];
   logic [31:0] f, t, wnew;

   assign wnew = {w_ff[13] ^ w_ff[8] ^ w_ff[2] ^ w_ff[0]} << 1
               | (w_ff[13] ^ w_ff[8] ^ w_ff[2] ^ w_ff[0]) >> 31;

   always_comb begin
      if (ctl.rnd < 7'd20) f = (v_ff[1] & v_ff[2]) | (~v_ff[1] & v_ff[3]);
      else if (ctl.rnd >= 7'd40 && ctl.rnd < 7'd60)
         f = (v_ff[1] & v_ff[2]) | (v_ff[1] & v_ff[3]) | (v_ff[2] & v_ff[3]);
      else f = v_ff[1] ^ v_ff[2] ^ v_ff[3];
      t = {v_ff[0][26:0], v_ff[0][31:27]} + f + v_ff[4] + sha_k(ctl.rnd) + w_ff[0];
   end

   always_comb begin
      w_in = w_ff;
      v_in = v_ff;
      h_in = h_ff;
      if (ctl.load) begin
         if (ctl.init_iv) begin
            h_in[0] = 32'h67452301; h_in[1] = 32'hefcdab89; h_in[2] = 32'h98badcfe;
            h_in[3] = 32'h10325476; h_in[4] = 32'hc3d2e1f0;
         end
         for (int i = 0; i < 16; i++) w_in[i] = block[511-32*i -: 32];
         for (int i = 0; i < 5; i++) v_in[i] = h_in[i];
      end else if (ctl.round) begin
         for (int i = 0; i < 15; i++) w_in[i] = w_ff[i+1];
         w_in[15] = wnew;
         v_in[0] = t;
         v_in[1] = v_ff[0];
         v_in[2] = {v_ff[1][1:0], v_ff[1][31:2]};
         v_in[3] = v_ff[2];
         v_in[4] = v_ff[3];
      end else if (ctl.fold) begin
         for (int i = 0; i < 5; i++) h_in[i] = h_ff[i] + v_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      w_ff <= w_in;
      v_ff <= v_in;
      h_ff <= h_in;
   end

   assign digest = {h_ff[0], h_ff[1], h_ff[2], h_ff[3], h_ff[4]};
endmodule

[rtl/hmac_sha1_fixed_key_mac.sv]
// channel | direction | handshake            | payload
// req     | in        | start & !busy        | req_message
// rsp     | out       | rsp_valid, one cycle | rsp_mac_word0..4
// csr     | in        | csr_valid & csr_ready| csr_index, csr_data
// One word runs four blocks, each of 1 load + 80 rounds + 1 fold, then a done state,
// all in the single shared SHA-1 round unit at one round per cycle.
// A new word is accepted only once the last is through; busy holds off start meanwhile.
// Reset is synchronous; it clears the sequencer and the key registers.
// The result strobe lasts one cycle; the receiver cannot stall.
module hmac_sha1_fixed_key_mac
   import hsha_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic [63:0]            req_message,
   output logic                   rsp_valid,
   output logic [31:0]            rsp_mac_word0,
   output logic [31:0]            rsp_mac_word1,
   output logic [31:0]            rsp_mac_word2,
   output logic [31:0]            rsp_mac_word3,
   output logic [31:0]            rsp_mac_word4,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CsrIdxWidth-1:0] csr_index,
   input  logic [63:0]            csr_data
);
`include "hmac_sha1_fixed_key_mac_assert.svh"
   state_type state_ff, state_in;
   logic [6:0] rnd_ff, rnd_in;
   logic [1:0] blk_ff, blk_in;
   logic [63:0] key_ff [KeyRegs];
   logic [63:0] msg_ff;
   logic [159:0] inner_ff, digest;
   logic [511:0] block;
   logic [31:0] pad;
   core_ctl_type ctl;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < KeyRegs; i++) key_ff[i] <= '0;
      end else if (csr_valid && csr_ready) begin
         key_ff[csr_index] <= csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (start && !busy) msg_ff <= req_message;
      if (ctl.load && blk_ff == 2'd2) inner_ff <= digest;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rnd_ff <= '0;
         blk_ff <= '0;
      end else begin
         state_ff <= state_in;
         rnd_ff <= rnd_in;
         blk_ff <= blk_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      rnd_in = rnd_ff;
      blk_in = blk_ff;
      case (state_ff)
         ST_IDLE: if (start) begin
            state_in = ST_LOAD;
            blk_in = '0;
         end
         ST_LOAD: begin
            state_in = ST_ROUND;
            rnd_in = '0;
         end
         ST_ROUND: begin
            rnd_in = rnd_ff + 7'd1;
            if (rnd_ff == 7'd79) state_in = ST_FOLD;
         end
         ST_FOLD: begin
            blk_in = blk_ff + 2'd1;
            state_in = (blk_ff == 2'd3) ? ST_DONE : ST_LOAD;
         end
         ST_DONE: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      pad = blk_ff[1] ? OpadWord : IpadWord;
      for (int i = 0; i < KeyRegs; i++) begin
         block[511-64*i -: 64] = key_ff[i] ^ {pad, pad};
      end
      case (blk_ff)
         2'd1: block = {msg_ff, 32'h80000000, 384'd0, InnerLen};
         2'd3: block = {inner_ff, 32'h80000000, 288'd0, OuterLen};
         default: ;
      endcase
   end

   always_comb begin
      ctl = '0;
      ctl.rnd = rnd_ff;
      case (state_ff)
         ST_LOAD: begin
            ctl.load = 1'b1;
            ctl.init_iv = !blk_ff[0];
         end
         ST_ROUND: ctl.round = 1'b1;
         ST_FOLD: ctl.fold = 1'b1;
         default: ;
      endcase
   end

   hsha_round u_round (
      .clock (clock),
      .ctl   (ctl),
      .block (block),
      .digest(digest)
   );

   assign busy = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_DONE);
   assign rsp_mac_word0 = digest[159:128];
   assign rsp_mac_word1 = digest[127:96];
   assign rsp_mac_word2 = digest[95:64];
   assign rsp_mac_word3 = digest[63:32];
   assign rsp_mac_word4 = digest[31:0];

   `ASSERT_NEXT(a_start_busy, clock, reset, start && !busy, busy)
   `ASSERT_NEXT(a_done_idle, clock, reset, rsp_valid, !busy)
   `ASSERT_IMPLY(a_rnd_range, clock, reset, state_ff == ST_ROUND, rnd_ff < 7'd80)
   `ASSERT_IMPLY(a_done_blk, clock, reset, rsp_valid, blk_ff == 2'd0)
endmodule

[verif/tb.sv]
`timescale 1ns / 1ps

module tb;
   import hsha_pkg::*;

   typedef struct {
      logic [31:0] w [5];
   } mac_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   start = 1'b0;
   logic                   busy;
   logic [63:0]            req_message = '0;
   logic                   rsp_valid;
   logic [31:0]            rsp_mac_word0, rsp_mac_word1, rsp_mac_word2;
   logic [31:0]            rsp_mac_word3, rsp_mac_word4;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CsrIdxWidth-1:0] csr_index = '0;
   logic [63:0]            csr_data = '0;

   hmac_sha1_fixed_key_mac uut (.*);

   always #1 clock = ~clock;

   logic [63:0] key_regs [KeyRegs];
   logic [63:0] message_queue [$];
   mac_type     mac_queue [$];
   int          idle_pct = 0;
   int          fails = 0;
   int          quiet = 0;
   int          accepted = 0;

   function automatic logic [31:0] rol(input logic [31:0] x, input int n);
      return (x << n) | (x >> (32 - n));
   endfunction

   function automatic void compress(ref logic [31:0] h [5], input logic [31:0] blk [16]);
      logic [31:0] w [80];
      logic [31:0] a, b, c, d, e, f, k, t;
      for (int r = 0; r < 16; r++) w[r] = blk[r];
      for (int r = 16; r < 80; r++) w[r] = rol(w[r-3] ^ w[r-8] ^ w[r-14] ^ w[r-16], 1);
      a = h[0]; b = h[1]; c = h[2]; d = h[3]; e = h[4];
      for (int r = 0; r < 80; r++) begin
         if (r < 20) begin
            f = (b & c) | (~b & d); k = 32'h5a827999;
         end else if (r < 40) begin
            f = b ^ c ^ d; k = 32'h6ed9eba1;
         end else if (r < 60) begin
            f = (b & c) | (b & d) | (c & d); k = 32'h8f1bbcdc;
         end else begin
            f = b ^ c ^ d; k = 32'hca62c1d6;
         end
         t = rol(a, 5) + f + e + k + w[r];
         e = d; d = c; c = rol(b, 30); b = a; a = t;
      end
      h[0] += a; h[1] += b; h[2] += c; h[3] += d; h[4] += e;
   endfunction

   function automatic void keyed_hash(ref logic [31:0] h [5], input logic [31:0] pad,
                                      input logic [31:0] tail [16]);
      logic [31:0] blk [16];
      h = '{32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476, 32'hc3d2e1f0};
      for (int i = 0; i < KeyRegs; i++) begin
         blk[2*i] = key_regs[i][63:32] ^ pad;
         blk[2*i+1] = key_regs[i][31:0] ^ pad;
      end
      compress(h, blk);
      compress(h, tail);
   endfunction

   function automatic mac_type compute_mac(input logic [63:0] msg);
      logic [31:0] inner [5];
      logic [31:0] outer [5];
      logic [31:0] blk [16];
      mac_type m;
      foreach (blk[i]) blk[i] = '0;
      blk[0] = msg[63:32]; blk[1] = msg[31:0]; blk[2] = 32'h80000000; blk[15] = InnerLen;
      keyed_hash(inner, IpadWord, blk);
      foreach (blk[i]) blk[i] = '0;
      for (int j = 0; j < 5; j++) blk[j] = inner[j];
      blk[5] = 32'h80000000; blk[15] = OuterLen;
      keyed_hash(outer, OpadWord, blk);
      for (int j = 0; j < 5; j++) m.w[j] = outer[j];
      return m;
   endfunction

   task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
      $display("mismatch %s: got %h want %h", what, got, want);
      fails++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (start && !busy) begin
         accepted++;
         mac_queue.push_back(compute_mac(req_message));
         if (message_queue.size() != 0 && $urandom_range(99) >= idle_pct) begin
            req_message <= message_queue.pop_front();
         end else begin
            start <= 1'b0;
         end
      end else if (!start && message_queue.size() != 0 && $urandom_range(99) >= idle_pct) begin
         start <= 1'b1;
         req_message <= message_queue.pop_front();
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         mac_type got, want;
         got.w = '{rsp_mac_word0, rsp_mac_word1, rsp_mac_word2, rsp_mac_word3, rsp_mac_word4};
         if (mac_queue.size() == 0) begin
            report("unexpected mac_word0", rsp_mac_word0, '0);
         end else begin
            want = mac_queue.pop_front();
            for (int j = 0; j < 5; j++)
               if (got.w[j] !== want.w[j]) report($sformatf("mac_word%0d", j), got.w[j], want.w[j]);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (csr_valid && csr_ready)) quiet <= 0;
      else quiet <= quiet + 1;
      if (quiet > 20000) begin
         $display("tb: failure");
         $finish;
      end
   end

   task automatic write_key(input int idx, input logic [63:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx[CsrIdxWidth-1:0];
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      key_regs[idx] = value;
   endtask

   task automatic drain();
      while (message_queue.size() != 0 || start || mac_queue.size() != 0) @(posedge clock);
      repeat (340) @(posedge clock);
   endtask

   task automatic load_key(input int mode);
      for (int i = 0; i < KeyRegs; i++)
         case (mode)
            0: write_key(i, '0);
            1: write_key(i, '1);
            default: write_key(i, {$urandom, $urandom});
         endcase
      csr_valid <= 1'b0;
   endtask

   task automatic run_phase(input int pct, input int count);
      idle_pct = pct;
      for (int i = 0; i < count; i++) begin
         case ($urandom_range(7))
            0: message_queue.push_back(64'd1 << $urandom_range(63));
            1: message_queue.push_back(~(64'd1 << $urandom_range(63)));
            2: message_queue.push_back(64'($urandom_range(100000)));
            default: message_queue.push_back({$urandom, $urandom});
         endcase
      end
      drain();
   endtask

   initial begin
      foreach (key_regs[i]) key_regs[i] = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      idle_pct = 0;
      message_queue = '{64'h0, 64'hffffffffffffffff, 64'h8000000000000001,
                        64'h0000000000000001, 64'h0123456789abcdef};
      drain();
      load_key(1);
      message_queue = '{64'h0, 64'hffffffffffffffff, 64'h5555555555555555,
                        64'haaaaaaaaaaaaaaaa};
      drain();
      load_key(2);
      message_queue = '{64'h0, 64'hffffffffffffffff, 64'h0000000000000030};
      drain();
      run_phase(0, 150);
      load_key(2);
      run_phase(51, 150);
      load_key(0);
      run_phase(31, 150);
      load_key(1);
      run_phase(0, 150);
      load_key(2);
      run_phase(51, 150);
      if (fails == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end
endmodule

[files.f]
+incdir+rtl
rtl/hsha_pkg.sv
rtl/hsha_round.sv
rtl/hmac_sha1_fixed_key_mac.sv
verif/tb.sv
